// ===== rtl/core/mdt_pkg.sv =====
package mdt_pkg;

  localparam int unsigned PIXEL_W    = 32;
  localparam int unsigned LANES      = 4;
  localparam int unsigned LANE_W     = 8;
  localparam int unsigned LANE_SUM_W = 9;
  localparam int unsigned PAIR_W     = LANES * LANE_SUM_W;
  localparam int unsigned WORD_W     = 18;
  localparam int unsigned CFG_W      = 4;
  localparam int unsigned MIN_LOG2   = 3;
  localparam int unsigned RESET_LOG2 = 6;
  localparam int unsigned OUT_DATA_W = 56;

  typedef logic [PAIR_W-1:0] pair_t;

  // Word handed from the read stage to the output stage.
  typedef struct packed {
    logic [WORD_W-1:0] word_index;
    pair_t             pair_sum;
    logic              last;
  } s1_t;

  // Add the byte lanes of two pixels into four 9-bit sums.
  function automatic pair_t lane_pairs(input logic [PIXEL_W-1:0] a,
                                       input logic [PIXEL_W-1:0] b);
    pair_t r;
    r = '0;
    for (int k = 0; k < LANES; k++) begin
      r[k*LANE_SUM_W +: LANE_SUM_W] = LANE_SUM_W'(a[k*LANE_W +: LANE_W])
                                    + LANE_SUM_W'(b[k*LANE_W +: LANE_W]);
    end
    return r;
  endfunction

  // Interleave the low three bits of x and j, x in the even positions.
  function automatic logic [5:0] interleave3(input logic [2:0] x, input logic [2:0] j);
    return {j[2], x[2], j[1], x[1], j[0], x[0]};
  endfunction

endpackage

// ===== rtl/core/mdt_line_store.sv =====
module mdt_line_store #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  mdt_pkg::pair_t             wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output mdt_pkg::pair_t             rdata_o
);

  mdt_pkg::pair_t mem [DEPTH];
  mdt_pkg::pair_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Hold the read word until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/mdt_out_stage.sv =====
module mdt_out_stage (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s1_valid_i,
  input  mdt_pkg::s1_t                        s1_i,
  input  mdt_pkg::pair_t                      above_i,
  output logic                                free_o,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [mdt_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                m_axis_tlast
);

  logic                              valid_q, valid_d;
  logic [mdt_pkg::WORD_W-1:0]        word_q;
  logic [mdt_pkg::PIXEL_W-1:0]       pixel_q, pixel_d;
  logic                              last_q;
  logic                              take;

  assign free_o = !valid_q || m_axis_tready;
  assign take   = s1_valid_i && free_o;

  always_comb begin
    logic [mdt_pkg::LANE_SUM_W:0] s;
    pixel_d = '0;
    for (int k = 0; k < mdt_pkg::LANES; k++) begin
      s = {1'b0, above_i[k*mdt_pkg::LANE_SUM_W +: mdt_pkg::LANE_SUM_W]}
        + {1'b0, s1_i.pair_sum[k*mdt_pkg::LANE_SUM_W +: mdt_pkg::LANE_SUM_W]};
      pixel_d[k*mdt_pkg::LANE_W +: mdt_pkg::LANE_W] = s[mdt_pkg::LANE_SUM_W:2];
    end
  end

  always_comb begin
    if (take) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      word_q  <= s1_i.word_index;
      pixel_q <= pixel_d;
      last_q  <= s1_i.last;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {{(mdt_pkg::OUT_DATA_W - mdt_pkg::WORD_W - mdt_pkg::PIXEL_W){1'b0}},
                          pixel_q, word_q};
  assign m_axis_tlast  = last_q;

endmodule

// ===== rtl/core/mip_downscale_tiler_unit.sv =====
// 2x2 box-filter downscaler with 8x8 Morton-tiled output addressing.
// Input: one RGBA8 source word per s_axis handshake, raster order from row 0,
// source side = 2 << out_size_log2. Output: one averaged pixel per 2x2 block,
// emitted on the odd column of each odd source row, with its tiled word index
// (rows flipped vertically); tlast marks the last pixel of the frame.
// Even source rows park horizontal pair sums in a line store of MAX_OUT_SIZE
// entries; odd rows read them back and finish the average.
// Path: an emitted word is loaded into the read stage as the line store is read,
// then into the output register, which drives m_axis.
// Throughput: one input word per cycle while m_axis_tready stays high; the
// line store has separate read and write ports and each row touches only one.
// Stall: with the output register and read stage both full and m_axis_tready low,
// s_axis_tready drops; nothing is lost or repeated.
// Reset: counters restart at row 0 column 0, out_size_log2 = 6, no line
// store clearing is needed. Writing cfg_wdata_i (only while idle) also
// restarts the frame counters. Sizes outside 3..log2(MAX_OUT_SIZE) saturate.
module mip_downscale_tiler_unit #(
  parameter int unsigned MAX_OUT_SIZE = 512
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mdt_pkg::CFG_W-1:0]           cfg_wdata_i,    // out_size_log2
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [mdt_pkg::PIXEL_W-1:0]         s_axis_tdata,   // [31:0] pixel
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [mdt_pkg::OUT_DATA_W-1:0]      m_axis_tdata,   // [17:0] word_index,
                                                              // [49:18] tiled_pixel
  output logic                                m_axis_tlast    // last
);

  localparam int unsigned XW     = $clog2(MAX_OUT_SIZE);
  localparam int unsigned CW     = XW + 1;
  localparam int unsigned MAXLOG = $clog2(MAX_OUT_SIZE + 1) - 1;
  localparam int unsigned IW     = (2 * XW + 2 > mdt_pkg::WORD_W) ? 2 * XW + 2
                                                                : mdt_pkg::WORD_W;

  logic [mdt_pkg::CFG_W-1:0]   cfg_q;
  logic [mdt_pkg::CFG_W-1:0]   lg;
  logic [CW-1:0]               col_q, col_d;
  logic [CW-1:0]               row_q, row_d;
  logic [CW-1:0]               side_m1;
  logic [XW-1:0]               size_m1;
  logic [XW-1:0]               x, y, j;
  logic [mdt_pkg::PIXEL_W-1:0] held_q;
  logic                        accept;
  logic                        odd_col, odd_row;
  logic                        emit;
  logic [IW-1:0]               word_full;
  mdt_pkg::pair_t              pair;
  mdt_pkg::pair_t              above;
  mdt_pkg::s1_t                s1_q, s1_d;
  logic                        s1_valid_q, s1_valid_d;
  logic                        out_free;

  // Saturate the configured size between MIN_LOG2 and what the line store can hold.
  always_comb begin
    if (cfg_q < mdt_pkg::CFG_W'(mdt_pkg::MIN_LOG2)) begin
      lg = mdt_pkg::CFG_W'(mdt_pkg::MIN_LOG2);
    end else if (cfg_q > mdt_pkg::CFG_W'(MAXLOG)) begin
      lg = mdt_pkg::CFG_W'(MAXLOG);
    end else begin
      lg = cfg_q;
    end
  end

  assign side_m1 = (CW'(2) << lg) - CW'(1);
  assign size_m1 = XW'((CW'(1) << lg) - CW'(1));

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign odd_col = col_q[0];
  assign odd_row = row_q[0];
  assign emit    = accept && odd_col && odd_row;
  assign x       = col_q[CW-1:1];
  assign y       = row_q[CW-1:1];
  assign j       = ~y & size_m1;   // flip rows: size-1-y

  assign pair = mdt_pkg::lane_pairs(held_q, s_axis_tdata);

  // Tiled index: Morton within the 8x8 tile, tiles of 64 words along a row.
  assign word_full = IW'(mdt_pkg::interleave3(x[2:0], j[2:0]))
                   + ((IW'(x) & ~IW'(7)) << 3)
                   + ((IW'(j) & ~IW'(7)) << lg);

  always_comb begin
    s1_d.word_index = word_full[mdt_pkg::WORD_W-1:0];
    s1_d.pair_sum   = pair;
    s1_d.last       = (x == size_m1) && (y == size_m1);
  end

  // Step raster counters on every accepted word, wrap at frame end; cfg_we_i clears.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_q == side_m1) begin
        col_d = '0;
        row_d = (row_q == side_m1) ? '0 : row_q + CW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  // Read stage holds while the output register is full and not draining.
  always_comb begin
    if (emit) begin
      s1_valid_d = 1'b1;
    end else if (out_free) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  assign s_axis_tready = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      <= mdt_pkg::CFG_W'(mdt_pkg::RESET_LOG2);
      col_q      <= '0;
      row_q      <= '0;
      held_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
      if (accept && !odd_col) begin
        held_q <= s_axis_tdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_q <= s1_d;
    end
  end

  // Even rows write pair sums, odd rows read them; one port each.
  mdt_line_store #(
    .DEPTH (MAX_OUT_SIZE),
    .AW    (XW)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (accept && odd_col && !odd_row),
    .waddr_i (x),
    .wdata_i (pair),
    .re_i    (emit),
    .raddr_i (x),
    .rdata_o (above)
  );

  mdt_out_stage u_out_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s1_valid_i    (s1_valid_q),
    .s1_i          (s1_q),
    .above_i       (above),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== tb/sv/mip_downscale_tiler_unit_tb.sv =====
`timescale 1ns / 100ps

module mip_downscale_tiler_unit_tb;

  localparam int unsigned MAX_OUT      = 512;
  localparam int unsigned LOG2_CAP     = $clog2(MAX_OUT + 1) - 1;
  localparam int unsigned SETTLE_TICKS = 8;
  localparam int unsigned HOLD_TICKS   = 300;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 48;
  localparam int unsigned REPORT_CAP   = 100;

  typedef struct {
    logic [mdt_pkg::WORD_W-1:0]  word_index;
    logic [mdt_pkg::PIXEL_W-1:0] tiled_pixel;
    logic                        last;
  } tile_px_t;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_we_i      = 1'b0;
  logic [mdt_pkg::CFG_W-1:0]      cfg_wdata_i   = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [mdt_pkg::PIXEL_W-1:0]    s_axis_tdata  = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [mdt_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tlast;

  // Predictor state: size register, raster position, held even-column pixel
  // and the row of pair sums left by the last even row.
  logic [mdt_pkg::CFG_W-1:0]   size_cfg;
  int unsigned                 col_now;
  int unsigned                 row_now;
  logic [mdt_pkg::PIXEL_W-1:0] held_px;
  logic [mdt_pkg::LANES-1:0][mdt_pkg::LANE_SUM_W-1:0] pair_line [MAX_OUT];

  tile_px_t    tiles_due[$];
  int unsigned errors      = 0;
  int unsigned cycle_count = 0;
  bit          idle_on     = 1'b1;
  bit          hold_req    = 1'b0;

  mip_downscale_tiler_unit #(
    .MAX_OUT_SIZE (MAX_OUT)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Saturate the size register to the supported output sides.
  function automatic int unsigned clamp_log2(input logic [mdt_pkg::CFG_W-1:0] v);
    int unsigned lg;
    lg = 32'(v);
    if (lg < mdt_pkg::MIN_LOG2) lg = mdt_pkg::MIN_LOG2;
    if (lg > LOG2_CAP) lg = LOG2_CAP;
    return lg;
  endfunction

  // Mostly no gap, some short ones, a few long ones.
  function automatic int unsigned pick_gap(input int unsigned zero_pct);
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < zero_pct) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Advance the predictor by one source pixel; queue the averaged word on the
  // odd column of an odd row.
  task automatic downscale_pixel(input logic [mdt_pkg::PIXEL_W-1:0] px);
    int unsigned size, side, x, y, j, word;
    logic [mdt_pkg::LANES-1:0][mdt_pkg::LANE_SUM_W-1:0] pair;
    logic [mdt_pkg::LANE_SUM_W:0]                       quad;
    logic [mdt_pkg::PIXEL_W-1:0]                        avg;
    logic [5:0]                                         zorder;
    tile_px_t                                           item;
    size = 1 << clamp_log2(size_cfg);
    side = size << 1;
    x    = col_now >> 1;
    if (!col_now[0]) begin
      held_px = px;
    end else if (x < MAX_OUT) begin
      for (int k = 0; k < mdt_pkg::LANES; k++) begin
        pair[k] = mdt_pkg::LANE_SUM_W'(held_px[k*mdt_pkg::LANE_W +: mdt_pkg::LANE_W])
                + mdt_pkg::LANE_SUM_W'(px[k*mdt_pkg::LANE_W +: mdt_pkg::LANE_W]);
      end
      if (!row_now[0]) begin
        pair_line[x] = pair;
      end else begin
        for (int k = 0; k < mdt_pkg::LANES; k++) begin
          quad = (mdt_pkg::LANE_SUM_W + 1)'(pair_line[x][k])
               + (mdt_pkg::LANE_SUM_W + 1)'(pair[k]);
          avg[k*mdt_pkg::LANE_W +: mdt_pkg::LANE_W] = quad[mdt_pkg::LANE_SUM_W:2];
        end
        y = row_now >> 1;
        j = (size - 1 - y) & (size - 1);
        for (int b = 0; b < 3; b++) begin
          zorder[2*b]     = x[b];
          zorder[2*b + 1] = j[b];
        end
        word = 32'(zorder) + (x & ~32'd7) * 8 + (j & ~32'd7) * size;
        item.word_index  = word[mdt_pkg::WORD_W-1:0];
        item.tiled_pixel = avg;
        item.last        = (x == size - 1) && (y == size - 1);
        tiles_due.push_back(item);
      end
    end
    if (col_now + 1 >= side) begin
      col_now = 0;
      row_now = (row_now + 1 >= side) ? 0 : row_now + 1;
    end else begin
      col_now++;
    end
  endtask

  // Track register writes and accepted pixels on the edge they happen.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_cfg = mdt_pkg::CFG_W'(mdt_pkg::RESET_LOG2);
      col_now  = 0;
      row_now  = 0;
      held_px  = '0;
    end else begin
      if (cfg_we_i) begin
        size_cfg = cfg_wdata_i;
        col_now  = 0;
        row_now  = 0;
      end
      if (s_axis_tvalid && s_axis_tready) downscale_pixel(s_axis_tdata);
    end
  end

  task automatic flag_mismatch(input string field, input logic [63:0] want_v,
                               input logic [63:0] got_v);
    errors++;
    if (errors <= REPORT_CAP) $error("%s: expected %0h, actual %0h", field, want_v, got_v);
  endtask

  // Compare every output word against the oldest prediction.
  always @(posedge clk_i) begin : check_out
    tile_px_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (tiles_due.size() == 0) begin
        flag_mismatch("unexpected word", 64'(0), 64'(m_axis_tdata));
      end else begin
        want = tiles_due.pop_front();
        if (m_axis_tdata[mdt_pkg::WORD_W-1:0] !== want.word_index)
          flag_mismatch("word_index", 64'(want.word_index),
                        64'(m_axis_tdata[mdt_pkg::WORD_W-1:0]));
        if (m_axis_tdata[mdt_pkg::WORD_W +: mdt_pkg::PIXEL_W] !== want.tiled_pixel)
          flag_mismatch("tiled_pixel", 64'(want.tiled_pixel),
                        64'(m_axis_tdata[mdt_pkg::WORD_W +: mdt_pkg::PIXEL_W]));
        if (m_axis_tlast !== want.last)
          flag_mismatch("last", 64'(want.last), 64'(m_axis_tlast));
      end
    end
  end

  // Output side: random stalls, or one long hold-off when asked for.
  initial begin : sink
    int unsigned stall;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_TICKS) @(posedge clk_i);
      end else begin
        stall = pick_gap(75);
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Offer one pixel; keep tvalid high across back-to-back words.
  task automatic send_pixel(input logic [mdt_pkg::PIXEL_W-1:0] px);
    int unsigned gap;
    gap = pick_gap(60);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_pixel($urandom());
  endtask

  // Drop tvalid, drain all predicted words, then let the pipeline empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (tiles_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic set_size(input logic [mdt_pkg::CFG_W-1:0] v);
    settle();
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Reset size (side 128): one even row and the start of the odd row, no
  // register write beforehand.
  task automatic test_reset_size();
    send_random((2 << mdt_pkg::RESET_LOG2) + 4);
  endtask

  // Size 0 saturates to the smallest side; lanes at all-ones, zero, and
  // sums that truncate on the divide.
  task automatic test_lane_extremes();
    logic [mdt_pkg::PIXEL_W-1:0] even_row [16];
    logic [mdt_pkg::PIXEL_W-1:0] odd_row  [16];
    even_row = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
                 32'hFFFF_FFFF, 32'h0000_0000, 32'h0101_0101, 32'h0101_0101,
                 32'h8000_0001, 32'h0000_0080, 32'h0302_0100, 32'h0302_0100,
                 32'hAAAA_AAAA, 32'h5555_5555, 32'hFEFE_FEFE, 32'hFFFF_FFFF};
    odd_row  = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
                 32'h0000_0000, 32'hFFFF_FFFF, 32'h0101_0101, 32'h0000_0000,
                 32'h7F00_FF00, 32'h0100_FF00, 32'h0302_0100, 32'h0201_0000,
                 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    set_size('0);
    foreach (even_row[i]) send_pixel(even_row[i]);
    foreach (odd_row[i]) send_pixel(odd_row[i]);
  endtask

  // One whole frame at the smallest side, then a row and two pixels past the
  // wrap: tlast, word 0 and the restart at row 0.
  task automatic test_full_frames();
    set_size(mdt_pkg::CFG_W'(mdt_pkg::MIN_LOG2));
    send_random(16 * 16 + 16 + 2);
  endtask

  // Hold the output off while the input keeps offering words.
  task automatic test_backpressure();
    set_size(mdt_pkg::CFG_W'(4));
    idle_on  = 1'b0;
    hold_req = 1'b1;
    send_random(2 * 32);
    idle_on  = 1'b1;
  endtask

  // All-ones register saturates to the largest side; start its first row.
  task automatic test_largest_size();
    set_size('1);
    send_random(16);
  endtask

  // Short runs at mostly small sides; some cut off mid row.
  task automatic test_random_frames();
    int unsigned total, side, count;
    logic [mdt_pkg::CFG_W-1:0] v;
    total = 0;
    while (total < RANDOM_ITEMS) begin
      v = ($urandom_range(0, 9) == 0) ? mdt_pkg::CFG_W'($urandom_range(6, 7))
                                      : mdt_pkg::CFG_W'($urandom_range(0, 5));
      side = 2 << clamp_log2(v);
      if (side == 16) count = $urandom_range(1, 2) * 2 * side;
      else if (side == 32) count = 2 * side;
      else count = $urandom_range(1, side);
      if ($urandom_range(0, 3) == 0) count = $urandom_range(1, count);
      if (count > RANDOM_ITEMS - total) count = RANDOM_ITEMS - total;
      set_size(v);
      idle_on = ($urandom_range(0, 3) != 0);
      send_random(count);
      total += count;
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_size();
    test_lane_extremes();
    test_full_frames();
    test_backpressure();
    test_largest_size();
    test_random_frames();
    settle();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
